FILE: sv/otbc_pkg.sv
// otbc_pkg: shared types, command and kind codes, and divide-by-three helpers
// for the outline to bezier command converter.
// No dependencies; used by outline_to_bezier_commands and otbc_checker.
`default_nettype none

package otbc_pkg;

    // field widths
    localparam int unsigned FIX_W   = 32;
    localparam int unsigned COORD_W = 18;
    localparam int unsigned BASE_W  = 15;
    localparam int unsigned MAG_W   = 34;
    localparam int unsigned HALF_W  = 17;

    // input point kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_SPLINE = 2'd2;

    // output command codes
    localparam logic [2:0] CMD_MOVE  = 3'd0;
    localparam logic [2:0] CMD_LINE  = 3'd1;
    localparam logic [2:0] CMD_CTRL1 = 3'd2;
    localparam logic [2:0] CMD_CTRL2 = 3'd3;
    localparam logic [2:0] CMD_END   = 3'd4;

    // register index (paddr[2])
    localparam logic REG_BASELINE = 1'b0;

    // reciprocal multipliers for exact floor(v / 3)
    localparam logic [16:0] DIV3_HI_MUL = 17'd87382;   // ceil(2^18 / 3)
    localparam logic [18:0] DIV3_LO_MUL = 19'd349526;  // ceil(2^20 / 3)

    // one output word
    typedef struct packed {
        logic [2:0]         cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } word_t;

    // everything but the bezier controls, carried down the pipe
    typedef struct packed {
        logic               has_pt;
        logic               bez;
        logic               pend;
        word_t              pt;
        word_t              endw;
        word_t              close;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
    } plan_t;

    // divider lane, before the high split
    typedef struct packed {
        logic [FIX_W-1:0] base;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } lane_a_t;

    // divider lane, after the high part
    typedef struct packed {
        logic [FIX_W-1:0]  base;
        logic              neg;
        logic [15:0]       qh;
        logic [1:0]        rh;
        logic [HALF_W-1:0] ml;
    } lane_b_t;

    // divider lane, full quotient
    typedef struct packed {
        logic [FIX_W-1:0] base;
        logic             neg;
        logic [32:0]      q;
    } lane_c_t;

    // floor(v / 3) for a 17 bit value
    function automatic logic [15:0] div3_hi(input logic [16:0] v);
        logic [33:0] p;
        p = {17'd0, v} * {17'd0, DIV3_HI_MUL};
        return p[33:18];
    endfunction

    // floor(v / 3) for a 19 bit value below 3 * 2^17
    function automatic logic [16:0] div3_lo(input logic [18:0] v);
        logic [37:0] p;
        p = {19'd0, v} * {19'd0, DIV3_LO_MUL};
        return p[36:20];
    endfunction

endpackage

`default_nettype wire

FILE: sv/outline_to_bezier_commands.sv
// outline_to_bezier_commands: outline points in, move / line / cubic bezier
// commands out, in device coordinates. Uses otbc_pkg for types and helpers.
//
//  channel   | ports                  | word
//  ----------+------------------------+-------------------------------------------
//  points in | s_tvalid/tready/...    | tdata px,py,origin_x,origin_y; tuser kind,
//            |                        | curve_end; tlast polygon_end
//  cmds out  | m_tvalid/tready/...    | tdata out_x,out_y; tuser cmd; tlast last
//  config    | psel/penable/pwrite/.. | reg 0 at 0x0: baseline[14:0]
//
// A point is taken every cycle while the pipe has room. Each point gives 0 to 4
// words at one word per cycle on the output register while m_tready is high, so
// a spline point that closes a segment gives 3 words (4 with a closing line).
// The first word passes the input reg, prep, two divide-by-three stages and the
// output reg. Synchronous reset empties the pipe and clears the outline state;
// m_tready low backs up through all stages.
`default_nettype none

module outline_to_bezier_commands (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // point stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // px_fixed, py_fixed, origin_x, origin_y
    input  wire logic [2:0]  s_tuser,   // kind, curve_end
    input  wire logic        s_tlast,   // polygon_end
    // command stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_x, out_y, zero fill
    output logic [2:0]       m_tuser,   // cmd
    output logic             m_tlast,   // last
    // config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned CW = otbc_pkg::COORD_W;

    // config register
    logic [otbc_pkg::BASE_W-1:0] baseline_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == otbc_pkg::REG_BASELINE);
    assign prdata = (paddr[2] == otbc_pkg::REG_BASELINE) ? {17'd0, baseline_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= '0;
        end else if (cfg_wr) begin
            baseline_reg <= pwdata[otbc_pkg::BASE_W-1:0];
        end
    end

    // pipeline handshake
    logic s0_v_reg, s1_v_reg, s2_v_reg, s3_v_reg;
    logic s0_rdy, s1_rdy, s2_rdy, s3_rdy, em_rdy;
    logic in_fire, fire0;
    logic [2:0] em_cnt_reg, em_cnt_next;
    logic take;

    assign take     = m_tvalid && m_tready;
    assign em_rdy   = (em_cnt_reg == 3'd0) || ((em_cnt_reg == 3'd1) && m_tready);
    assign s3_rdy   = !s3_v_reg || em_rdy;
    assign s2_rdy   = !s2_v_reg || s3_rdy;
    assign s1_rdy   = !s1_v_reg || s2_rdy;
    assign s0_rdy   = !s0_v_reg || s1_rdy;
    assign s_tready = s0_rdy;
    assign in_fire  = s_tvalid && s_tready;
    assign fire0    = s0_v_reg && s1_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else begin
            if (s0_rdy) s0_v_reg <= s_tvalid;
            if (s1_rdy) s1_v_reg <= s0_v_reg;
            if (s2_rdy) s2_v_reg <= s1_v_reg;
            if (s3_rdy) s3_v_reg <= s2_v_reg;
        end
    end

    // input register
    logic [1:0]  s0_kind_reg;
    logic [31:0] s0_px_reg, s0_py_reg;
    logic        s0_cend_reg, s0_pend_reg;
    logic [15:0] s0_ox_reg, s0_oy_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s0_px_reg   <= s_tdata[31:0];
            s0_py_reg   <= s_tdata[63:32];
            s0_ox_reg   <= s_tdata[79:64];
            s0_oy_reg   <= s_tdata[95:80];
            s0_kind_reg <= s_tuser[1:0];
            s0_cend_reg <= s_tuser[2];
            s0_pend_reg <= s_tlast;
        end
    end

    // outline state
    logic [31:0] seg_x_reg, seg_y_reg, held_x_reg, held_y_reg;
    logic [31:0] seg_x_next, seg_y_next, held_x_next, held_y_next;
    logic        held_v_reg, held_v_next;
    logic [15:0] poly_x_reg, poly_y_reg, pen_x_reg, pen_y_reg;
    logic [15:0] poly_x_next, poly_y_next, pen_x_next, pen_y_next;

    // prep: integer parts, segment end, differences
    logic [15:0]   ix, iy;
    logic [CW-1:0] ox18, oy18;
    logic          endc, bez;
    logic [32:0]   sum_x, sum_y;
    logic [31:0]   ex, ey;
    logic [32:0]   dba_x, dba_y;
    logic [33:0]   d1x, d1y, d2x, d2y;
    otbc_pkg::plan_t   s1_plan_next, s1_plan_reg;
    otbc_pkg::lane_a_t s1_lane_next [4];
    otbc_pkg::lane_a_t s1_lane_reg  [4];

    assign ix    = s0_px_reg[31:16];
    assign iy    = s0_py_reg[31:16];
    assign ox18  = {{2{s0_ox_reg[15]}}, s0_ox_reg};
    assign oy18  = {{2{s0_oy_reg[15]}}, s0_oy_reg} + {3'd0, baseline_reg};
    assign endc  = s0_cend_reg || s0_pend_reg;
    assign bez   = (s0_kind_reg == otbc_pkg::KIND_SPLINE) && held_v_reg;
    assign sum_x = {held_x_reg[31], held_x_reg} + {s0_px_reg[31], s0_px_reg};
    assign sum_y = {held_y_reg[31], held_y_reg} + {s0_py_reg[31], s0_py_reg};
    assign ex    = endc ? s0_px_reg : sum_x[32:1];
    assign ey    = endc ? s0_py_reg : sum_y[32:1];
    assign dba_x = {held_x_reg[31], held_x_reg} - {seg_x_reg[31], seg_x_reg};
    assign dba_y = {held_y_reg[31], held_y_reg} - {seg_y_reg[31], seg_y_reg};
    assign d1x   = {dba_x, 1'b0};
    assign d1y   = {dba_y, 1'b0};
    assign d2x   = {{2{ex[31]}}, ex} - {{2{held_x_reg[31]}}, held_x_reg};
    assign d2y   = {{2{ey[31]}}, ey} - {{2{held_y_reg[31]}}, held_y_reg};

    // state update for the point in the input register
    always_comb begin
        seg_x_next  = seg_x_reg;
        seg_y_next  = seg_y_reg;
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        held_v_next = held_v_reg;
        poly_x_next = poly_x_reg;
        poly_y_next = poly_y_reg;
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        case (s0_kind_reg)
            otbc_pkg::KIND_START: begin
                held_v_next = 1'b0;
                poly_x_next = ix;
                poly_y_next = iy;
                pen_x_next  = ix;
                pen_y_next  = iy;
            end
            otbc_pkg::KIND_LINE: begin
                held_v_next = 1'b0;
                pen_x_next  = ix;
                pen_y_next  = iy;
            end
            otbc_pkg::KIND_SPLINE: begin
                if (!held_v_reg) begin
                    // first point of a curve becomes the control point
                    seg_x_next  = {pen_x_reg, 16'd0};
                    seg_y_next  = {pen_y_reg, 16'd0};
                    held_x_next = s0_px_reg;
                    held_y_next = s0_py_reg;
                    held_v_next = !endc;
                end else if (endc) begin
                    held_v_next = 1'b0;
                    pen_x_next  = ex[31:16];
                    pen_y_next  = ey[31:16];
                end else begin
                    seg_x_next  = ex;
                    seg_y_next  = ey;
                    held_x_next = s0_px_reg;
                    held_y_next = s0_py_reg;
                end
            end
            default: begin
                held_v_next = 1'b0;
            end
        endcase
        if (s0_pend_reg) held_v_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_x_reg  <= '0;
            seg_y_reg  <= '0;
            held_x_reg <= '0;
            held_y_reg <= '0;
            held_v_reg <= 1'b0;
            poly_x_reg <= '0;
            poly_y_reg <= '0;
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
        end else if (fire0) begin
            seg_x_reg  <= seg_x_next;
            seg_y_reg  <= seg_y_next;
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
            held_v_reg <= held_v_next;
            poly_x_reg <= poly_x_next;
            poly_y_reg <= poly_y_next;
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
        end
    end

    // build the plan and divider lanes
    always_comb begin
        s1_plan_next.has_pt  = (s0_kind_reg == otbc_pkg::KIND_START) ||
                               (s0_kind_reg == otbc_pkg::KIND_LINE);
        s1_plan_next.bez     = bez;
        s1_plan_next.pend    = s0_pend_reg;
        s1_plan_next.pt.cmd  = (s0_kind_reg == otbc_pkg::KIND_START) ?
                               otbc_pkg::CMD_MOVE : otbc_pkg::CMD_LINE;
        s1_plan_next.pt.x    = ox18 + {{2{ix[15]}}, ix};
        s1_plan_next.pt.y    = oy18 - {{2{iy[15]}}, iy};
        s1_plan_next.endw.cmd = otbc_pkg::CMD_END;
        s1_plan_next.endw.x  = ox18 + {{2{ex[31]}}, ex[31:16]};
        s1_plan_next.endw.y  = oy18 - {{2{ey[31]}}, ey[31:16]};
        s1_plan_next.close.cmd = otbc_pkg::CMD_LINE;
        s1_plan_next.close.x = ox18 + {{2{poly_x_next[15]}}, poly_x_next};
        s1_plan_next.close.y = oy18 - {{2{poly_y_next[15]}}, poly_y_next};
        s1_plan_next.ox      = ox18;
        s1_plan_next.oy      = oy18;

        s1_lane_next[0].base = seg_x_reg;
        s1_lane_next[0].neg  = d1x[33];
        s1_lane_next[0].mag  = d1x[33] ? (~d1x + 34'd1) : d1x;
        s1_lane_next[1].base = seg_y_reg;
        s1_lane_next[1].neg  = d1y[33];
        s1_lane_next[1].mag  = d1y[33] ? (~d1y + 34'd1) : d1y;
        s1_lane_next[2].base = held_x_reg;
        s1_lane_next[2].neg  = d2x[33];
        s1_lane_next[2].mag  = d2x[33] ? (~d2x + 34'd1) : d2x;
        s1_lane_next[3].base = held_y_reg;
        s1_lane_next[3].neg  = d2y[33];
        s1_lane_next[3].mag  = d2y[33] ? (~d2y + 34'd1) : d2y;
    end

    // divide stage one: high half
    otbc_pkg::plan_t   s2_plan_reg, s3_plan_reg;
    otbc_pkg::lane_b_t s2_lane_next [4];
    otbc_pkg::lane_b_t s2_lane_reg  [4];
    otbc_pkg::lane_c_t s3_lane_next [4];
    otbc_pkg::lane_c_t s3_lane_reg  [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s2_lane_next[i].base = s1_lane_reg[i].base;
            s2_lane_next[i].neg  = s1_lane_reg[i].neg;
            s2_lane_next[i].qh   = otbc_pkg::div3_hi(s1_lane_reg[i].mag[33:17]);
            s2_lane_next[i].rh   = 2'(s1_lane_reg[i].mag[33:17]
                                   - {s2_lane_next[i].qh, 1'b0} - {1'b0, s2_lane_next[i].qh});
            s2_lane_next[i].ml   = s1_lane_reg[i].mag[16:0];
        end
    end

    // divide stage two: remainder folded into the low half
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s3_lane_next[i].base = s2_lane_reg[i].base;
            s3_lane_next[i].neg  = s2_lane_reg[i].neg;
            s3_lane_next[i].q    = {s2_lane_reg[i].qh,
                                    otbc_pkg::div3_lo({s2_lane_reg[i].rh, s2_lane_reg[i].ml})};
        end
    end

    always_ff @(posedge aclk) begin
        if (fire0) begin
            s1_plan_reg <= s1_plan_next;
            s1_lane_reg <= s1_lane_next;
        end
        if (s1_v_reg && s2_rdy) begin
            s2_plan_reg <= s1_plan_reg;
            s2_lane_reg <= s2_lane_next;
        end
        if (s2_v_reg && s3_rdy) begin
            s3_plan_reg <= s2_plan_reg;
            s3_lane_reg <= s3_lane_next;
        end
    end

    // control point coordinates from the quotients
    logic [33:0]   qs [4];
    logic [34:0]   csum [4];
    logic [CW-1:0] cdev [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qs[i]   = s3_lane_reg[i].neg ? (34'd0 - {1'b0, s3_lane_reg[i].q})
                                         : {1'b0, s3_lane_reg[i].q};
            csum[i] = {{3{s3_lane_reg[i].base[31]}}, s3_lane_reg[i].base} + {qs[i][33], qs[i]};
            // even lanes are x, odd lanes are y
            cdev[i] = i[0] ? (s3_plan_reg.oy - csum[i][33:16])
                           : (s3_plan_reg.ox + csum[i][33:16]);
        end
    end

    // output word queue, shifted out one word per cycle while m_tready is high
    otbc_pkg::word_t em_reg  [4];
    otbc_pkg::word_t em_next [4];
    logic            load;

    assign load = em_rdy && s3_v_reg;

    always_comb begin
        em_next     = em_reg;
        em_cnt_next = em_cnt_reg;
        if (load) begin
            em_cnt_next = 3'd0;
            if (s3_plan_reg.bez) begin
                em_next[0] = '{cmd: otbc_pkg::CMD_CTRL1, x: cdev[0], y: cdev[1]};
                em_next[1] = '{cmd: otbc_pkg::CMD_CTRL2, x: cdev[2], y: cdev[3]};
                em_next[2] = s3_plan_reg.endw;
                em_next[3] = s3_plan_reg.close;
                em_cnt_next = s3_plan_reg.pend ? 3'd4 : 3'd3;
            end else if (s3_plan_reg.has_pt) begin
                em_next[0] = s3_plan_reg.pt;
                em_next[1] = s3_plan_reg.close;
                em_cnt_next = s3_plan_reg.pend ? 3'd2 : 3'd1;
            end else begin
                em_next[0] = s3_plan_reg.close;
                em_cnt_next = s3_plan_reg.pend ? 3'd1 : 3'd0;
            end
        end else if (take) begin
            for (int i = 0; i < 3; i++) em_next[i] = em_reg[i+1];
            em_cnt_next = em_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_cnt_reg <= 3'd0;
        end else begin
            em_cnt_reg <= em_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        em_reg <= em_next;
    end

    // output port
    assign m_tvalid = (em_cnt_reg != 3'd0);
    assign m_tlast  = (em_cnt_reg == 3'd1);
    assign m_tuser  = em_reg[0].cmd;
    assign m_tdata  = {4'd0, em_reg[0].y, em_reg[0].x};

endmodule

`default_nettype wire

FILE: sv/otbc_checker.sv
// otbc_checker: port-level assertions for outline_to_bezier_commands,
// bound to the top level. Uses otbc_pkg for command codes.
`default_nettype none

module otbc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output word changed under stall");

    // reset leaves the output empty and the input open
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipe not empty after reset");

    // a taken first control word is always followed at once by a valid word
    a_ctrl_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser == otbc_pkg::CMD_CTRL1) |=> m_tvalid)
        else $error("bezier words not back to back");

    // baseline write reads back
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && (paddr[2] == otbc_pkg::REG_BASELINE)
        |=> (paddr[2] != otbc_pkg::REG_BASELINE) || (prdata[14:0] == $past(pwdata[14:0])))
        else $error("baseline readback mismatch");

endmodule

bind outline_to_bezier_commands otbc_checker u_otbc_checker (.*);

`default_nettype wire
